### rtl/segi_pkg.sv
// ----------------------------------------------------------------------------
// segi_pkg
// Shared constants for the 2D segment intersection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package segi_pkg;

	localparam int COORD_W_DEF = 16;
	localparam int COORD_W_MIN = 8;
	localparam int COORD_W_MAX = 32;

endpackage

`default_nettype wire

### rtl/segi_cross.sv
// ----------------------------------------------------------------------------
// segi_cross
// Front stages: edge vectors, six cross-product terms, then det, tn and un.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segi_cross #(
	parameter int W = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_vld,
	input  wire logic signed [W-1:0]  ax,
	input  wire logic signed [W-1:0]  ay,
	input  wire logic signed [W-1:0]  bx,
	input  wire logic signed [W-1:0]  by,
	input  wire logic signed [W-1:0]  cx,
	input  wire logic signed [W-1:0]  cy,
	input  wire logic signed [W-1:0]  dx,
	input  wire logic signed [W-1:0]  dy,
	output logic                      vld_s3,
	output logic signed [2*W+2:0]     det_s3,
	output logic signed [2*W+2:0]     tn_s3,
	output logic signed [2*W+2:0]     un_s3,
	output logic signed [W:0]         abx_s3,
	output logic signed [W:0]         aby_s3,
	output logic signed [W-1:0]       ax_s3,
	output logic signed [W-1:0]       ay_s3
);

	localparam int PW = 2*W + 2;
	localparam int XW = 2*W + 3;

	logic                  vld_s1, vld_s2;
	logic signed [W:0]     abx_s1, aby_s1, cdx_s1, cdy_s1, ccx_s1, ccy_s1;
	logic signed [W-1:0]   ax_s1, ay_s1, ax_s2, ay_s2;
	logic signed [W:0]     abx_s2, aby_s2;
	logic signed [PW-1:0]  p_det0_s2, p_det1_s2, p_tn0_s2, p_tn1_s2, p_un0_s2, p_un1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: edge vectors
			abx_s1 <= {bx[W-1], bx} - {ax[W-1], ax};
			aby_s1 <= {by[W-1], by} - {ay[W-1], ay};
			cdx_s1 <= {dx[W-1], dx} - {cx[W-1], cx};
			cdy_s1 <= {dy[W-1], dy} - {cy[W-1], cy};
			ccx_s1 <= {cx[W-1], cx} - {ax[W-1], ax};
			ccy_s1 <= {cy[W-1], cy} - {ay[W-1], ay};
			ax_s1  <= ax;
			ay_s1  <= ay;

			// s2: products
			p_det0_s2 <= abx_s1 * cdy_s1;
			p_det1_s2 <= aby_s1 * cdx_s1;
			p_tn0_s2  <= ccx_s1 * cdy_s1;
			p_tn1_s2  <= ccy_s1 * cdx_s1;
			p_un0_s2  <= ccx_s1 * aby_s1;
			p_un1_s2  <= ccy_s1 * abx_s1;
			abx_s2    <= abx_s1;
			aby_s2    <= aby_s1;
			ax_s2     <= ax_s1;
			ay_s2     <= ay_s1;

			// s3: cross products
			det_s3 <= XW'(p_det0_s2) - XW'(p_det1_s2);
			tn_s3  <= XW'(p_tn0_s2) - XW'(p_tn1_s2);
			un_s3  <= XW'(p_un0_s2) - XW'(p_un1_s2);
			abx_s3 <= abx_s2;
			aby_s3 <= aby_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
		end
	end

endmodule

`default_nettype wire

### rtl/segi_test.sv
// ----------------------------------------------------------------------------
// segi_test
// Bound tests on t and u, magnitudes, and the |AB| * |tn| numerators built
// from two half-width partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segi_test #(
	parameter int W = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  vld_s3,
	input  wire logic signed [2*W+2:0] det_s3,
	input  wire logic signed [2*W+2:0] tn_s3,
	input  wire logic signed [2*W+2:0] un_s3,
	input  wire logic signed [W:0]     abx_s3,
	input  wire logic signed [W:0]     aby_s3,
	input  wire logic signed [W-1:0]   ax_s3,
	input  wire logic signed [W-1:0]   ay_s3,
	output logic                       vld_s6,
	output logic                       hit_s6,
	output logic                       negx_s6,
	output logic                       negy_s6,
	output logic [3*W+1:0]             nx_s6,
	output logic [3*W+1:0]             ny_s6,
	output logic [2*W+1:0]             dm_s6,
	output logic signed [W-1:0]        ax_s6,
	output logic signed [W-1:0]        ay_s6
);

	localparam int XW = 2*W + 3;
	localparam int TW = 2*W + 2;
	localparam int H  = W + 1;
	localparam int NW = 3*W + 2;

	function automatic logic in_unit(input logic signed [XW-1:0] num,
	                                 input logic signed [XW-1:0] det);
		if (det[XW-1])
			return (num >= det) && (num <= 0);
		return (num >= 0) && (num <= det);
	endfunction

	logic signed [XW-1:0] ndet, ntn;
	logic signed [W:0]    nabx, naby;

	logic                 vld_s4, vld_s5;
	logic                 hit_s4, hit_s5, negx_s4, negx_s5, negy_s4, negy_s5;
	logic [TW-1:0]        dm_s4, dm_s5, tm_s4;
	logic [W-1:0]         mdx_s4, mdy_s4;
	logic [2*W:0]         pxl_s5, pxh_s5, pyl_s5, pyh_s5;
	logic signed [W-1:0]  ax_s4, ay_s4, ax_s5, ay_s5;

	assign ndet = -det_s3;
	assign ntn  = -tn_s3;
	assign nabx = -abx_s3;
	assign naby = -aby_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s4: decision and magnitudes
			hit_s4  <= (det_s3 != '0) && in_unit(tn_s3, det_s3) && in_unit(un_s3, det_s3);
			dm_s4   <= det_s3[XW-1] ? ndet[TW-1:0] : det_s3[TW-1:0];
			tm_s4   <= tn_s3[XW-1] ? ntn[TW-1:0] : tn_s3[TW-1:0];
			mdx_s4  <= abx_s3[W] ? nabx[W-1:0] : abx_s3[W-1:0];
			mdy_s4  <= aby_s3[W] ? naby[W-1:0] : aby_s3[W-1:0];
			negx_s4 <= abx_s3[W];
			negy_s4 <= aby_s3[W];
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;

			// s5: partial products, tm split in halves
			pxl_s5  <= mdx_s4 * tm_s4[H-1:0];
			pxh_s5  <= mdx_s4 * tm_s4[TW-1:H];
			pyl_s5  <= mdy_s4 * tm_s4[H-1:0];
			pyh_s5  <= mdy_s4 * tm_s4[TW-1:H];
			hit_s5  <= hit_s4;
			dm_s5   <= dm_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;

			// s6: recombine
			nx_s6   <= NW'(pxl_s5) + (NW'(pxh_s5) << H);
			ny_s6   <= NW'(pyl_s5) + (NW'(pyh_s5) << H);
			hit_s6  <= hit_s5;
			dm_s6   <= dm_s5;
			negx_s6 <= negx_s5;
			negy_s6 <= negy_s5;
			ax_s6   <= ax_s5;
			ay_s6   <= ay_s5;
		end
	end

endmodule

`default_nettype wire

### rtl/segi_div.sv
// ----------------------------------------------------------------------------
// segi_div
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over a shared denominator. Quotient must be below 2**Q_W.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segi_div #(
	parameter int NUM_W = 50,
	parameter int DEN_W = 34,
	parameter int Q_W   = 16,
	parameter int SB_W  = 35
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_vld,
	input  wire logic [NUM_W-1:0] num_a,
	input  wire logic [NUM_W-1:0] num_b,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [SB_W-1:0]  sb,
	output logic                  out_vld,
	output logic [Q_W-1:0]        q_a,
	output logic [Q_W-1:0]        q_b,
	output logic [SB_W-1:0]       out_sb
);

	logic             vld_s   [Q_W];
	logic [NUM_W-1:0] rem_a_s [Q_W];
	logic [NUM_W-1:0] rem_b_s [Q_W];
	logic [DEN_W-1:0] den_s   [Q_W];
	logic [Q_W-1:0]   qa_s    [Q_W];
	logic [Q_W-1:0]   qb_s    [Q_W];
	logic [SB_W-1:0]  sb_s    [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		localparam int I = Q_W - 1 - k;

		logic             vld_in;
		logic [NUM_W-1:0] ra_in, rb_in, dsh;
		logic [DEN_W-1:0] d_in;
		logic [Q_W-1:0]   qa_in, qb_in;
		logic [SB_W-1:0]  sb_in;
		logic             ge_a, ge_b;

		if (k == 0) begin : g_first
			assign vld_in = in_vld;
			assign ra_in  = num_a;
			assign rb_in  = num_b;
			assign d_in   = den;
			assign qa_in  = '0;
			assign qb_in  = '0;
			assign sb_in  = sb;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign ra_in  = rem_a_s[k-1];
			assign rb_in  = rem_b_s[k-1];
			assign d_in   = den_s[k-1];
			assign qa_in  = qa_s[k-1];
			assign qb_in  = qb_s[k-1];
			assign sb_in  = sb_s[k-1];
		end

		assign dsh  = NUM_W'(d_in) << I;
		assign ge_a = ra_in >= dsh;
		assign ge_b = rb_in >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_a_s[k]  <= ge_a ? ra_in - dsh : ra_in;
				rem_b_s[k]  <= ge_b ? rb_in - dsh : rb_in;
				qa_s[k]     <= qa_in | (Q_W'(ge_a) << I);
				qb_s[k]     <= qb_in | (Q_W'(ge_b) << I);
				den_s[k]    <= d_in;
				sb_s[k]     <= sb_in;
			end
		end
	end

	assign out_vld = vld_s[Q_W-1];
	assign q_a     = qa_s[Q_W-1];
	assign q_b     = qb_s[Q_W-1];
	assign out_sb  = sb_s[Q_W-1];

endmodule

`default_nettype wire

### rtl/segment_intersection_2d.sv
// Pipeline: from input to output, three cross-product stages, three
//   test/numerator stages, one divider stage per quotient bit, one
//   output register.
// Throughput: one item per cycle; the whole pipe holds while a result waits with out_ready low.
// Reset: arst_n clears all valid bits; items in flight are dropped and none is invented.
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Two-segment intersection in Q8.8 with exact arithmetic and a pipelined
// divider for the intersection point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_2d #(
	parameter int COORD_WIDTH = segi_pkg::COORD_W_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] ax,
	input  wire logic signed [COORD_WIDTH-1:0] ay,
	input  wire logic signed [COORD_WIDTH-1:0] bx,
	input  wire logic signed [COORD_WIDTH-1:0] by,
	input  wire logic signed [COORD_WIDTH-1:0] cx,
	input  wire logic signed [COORD_WIDTH-1:0] cy,
	input  wire logic signed [COORD_WIDTH-1:0] dx,
	input  wire logic signed [COORD_WIDTH-1:0] dy,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               hit,
	output logic signed [COORD_WIDTH-1:0]      ix,
	output logic signed [COORD_WIDTH-1:0]      iy
);

	import segi_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int NW   = 3*W + 2;
	localparam int TW   = 2*W + 2;
	localparam int SB_W = 2*W + 3;

	logic                 en;

	logic                 vld_s3;
	logic signed [2*W+2:0] det_s3, tn_s3, un_s3;
	logic signed [W:0]    abx_s3, aby_s3;
	logic signed [W-1:0]  ax_s3, ay_s3;

	logic                 vld_s6, hit_s6, negx_s6, negy_s6;
	logic [NW-1:0]        nx_s6, ny_s6;
	logic [TW-1:0]        dm_s6;
	logic signed [W-1:0]  ax_s6, ay_s6;

	logic                 dv_vld;
	logic [W-1:0]         qx, qy;
	logic [SB_W-1:0]      dv_sb;
	logic                 dv_hit, dv_negx, dv_negy;
	logic signed [W-1:0]  dv_ax, dv_ay;
	logic signed [W:0]    sx, sy;

	logic                 out_valid_q, hit_q;
	logic signed [W-1:0]  ix_q, iy_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	segi_cross #(.W(W)) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.ax     (ax),
		.ay     (ay),
		.bx     (bx),
		.by     (by),
		.cx     (cx),
		.cy     (cy),
		.dx     (dx),
		.dy     (dy),
		.vld_s3 (vld_s3),
		.det_s3 (det_s3),
		.tn_s3  (tn_s3),
		.un_s3  (un_s3),
		.abx_s3 (abx_s3),
		.aby_s3 (aby_s3),
		.ax_s3  (ax_s3),
		.ay_s3  (ay_s3)
	);

	segi_test #(.W(W)) u_test (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_s3  (vld_s3),
		.det_s3  (det_s3),
		.tn_s3   (tn_s3),
		.un_s3   (un_s3),
		.abx_s3  (abx_s3),
		.aby_s3  (aby_s3),
		.ax_s3   (ax_s3),
		.ay_s3   (ay_s3),
		.vld_s6  (vld_s6),
		.hit_s6  (hit_s6),
		.negx_s6 (negx_s6),
		.negy_s6 (negy_s6),
		.nx_s6   (nx_s6),
		.ny_s6   (ny_s6),
		.dm_s6   (dm_s6),
		.ax_s6   (ax_s6),
		.ay_s6   (ay_s6)
	);

	segi_div #(
		.NUM_W (NW),
		.DEN_W (TW),
		.Q_W   (W),
		.SB_W  (SB_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.num_a   (nx_s6),
		.num_b   (ny_s6),
		.den     (dm_s6),
		.sb      ({hit_s6, negx_s6, negy_s6, ax_s6, ay_s6}),
		.out_vld (dv_vld),
		.q_a     (qx),
		.q_b     (qy),
		.out_sb  (dv_sb)
	);

	assign {dv_hit, dv_negx, dv_negy, dv_ax, dv_ay} = dv_sb;

	// point lies on AB, so the low W bits are exact
	assign sx = dv_negx ? {dv_ax[W-1], dv_ax} - {1'b0, qx} : {dv_ax[W-1], dv_ax} + {1'b0, qx};
	assign sy = dv_negy ? {dv_ay[W-1], dv_ay} - {1'b0, qy} : {dv_ay[W-1], dv_ay} + {1'b0, qy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= dv_hit;
			ix_q  <= dv_hit ? sx[W-1:0] : '0;
			iy_q  <= dv_hit ? sy[W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign ix        = ix_q;
	assign iy        = iy_q;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (ix == '0 && iy == '0))
		else $error("miss item carries a non-zero point");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready ##1 (out_valid && $stable({hit, ix, iy})))
		else $error("pipe advanced while output stalled");

	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(en && dv_vld) |=> out_valid)
		else $error("divider item not delivered to output");

endmodule

`default_nettype wire
